### rtl/lphe_pkg.sv
`timescale 1ns / 1ps

package lphe_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NibW    = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxByte = 5;
  localparam int unsigned CntW    = 3;
  localparam int unsigned RawByte = 4;

  localparam logic [NibW-1:0] NibZero = 4'h0;
  localparam logic [NibW-1:0] NibOnes = 4'hf;

  typedef struct packed {
    logic [MaxByte-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]               cnt;
  } job_t;

endpackage

### rtl/lphe_front.sv
`timescale 1ns / 1ps

module lphe_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lphe_pkg::WordW-1:0] sample_value,
  input  logic                       end_of_stream,
  output logic                       job_valid,
  output lphe_pkg::job_t             job,
  input  logic                       job_full
);

  logic [lphe_pkg::WordW-1:0] older_value;
  logic [lphe_pkg::WordW-1:0] newer_value;
  logic [1:0]                 samples_seen;
  logic                       a_valid;
  logic [lphe_pkg::WordW-1:0] a_word;
  logic                       a_raw;
  logic                       a_eos;
  logic                       nibble_waiting;
  logic [lphe_pkg::NibW-1:0]  waiting_nibble;

  logic                       accept;
  logic                       a_take;
  logic                       raw_in;
  logic [lphe_pkg::WordW-1:0] pred;

  logic                       zmode;
  logic                       fmode;
  logic                       run;
  logic [3:0]                 lead;
  logic [3:0]                 head;
  logic [3:0]                 vcnt;
  logic [4:0]                 vi;
  logic [3:0]                 n;
  logic [3:0]                 n_m1;
  logic [lphe_pkg::NibW-1:0]  nib [16];
  logic [lphe_pkg::NibW-1:0]  cur;
  logic [lphe_pkg::WordW-1:0] shifted;

  assign in_stall = a_valid && job_full;
  assign accept   = in_valid && !in_stall;
  assign a_take   = a_valid && !job_full;
  assign raw_in   = (samples_seen < 2'd2);
  assign pred     = newer_value + newer_value - older_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      older_value  <= '0;
      newer_value  <= '0;
      samples_seen <= '0;
      a_valid      <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
        if (end_of_stream) begin
          older_value  <= '0;
          newer_value  <= '0;
          samples_seen <= '0;
        end else begin
          older_value <= newer_value;
          newer_value <= sample_value;
          if (raw_in) begin
            samples_seen <= samples_seen + 2'd1;
          end
        end
      end else if (a_take) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_word <= raw_in ? sample_value : sample_value - pred;
      a_raw  <= raw_in;
      a_eos  <= end_of_stream;
    end
  end

  always_comb begin
    zmode = (a_word[31:28] == lphe_pkg::NibZero);
    fmode = (a_word[31:28] == lphe_pkg::NibOnes);
    lead  = '0;
    run   = 1'b1;
    for (int k = 0; k < 8; k++) begin
      cur = a_word[28-4*k +: 4];
      if (run && ((zmode && cur == lphe_pkg::NibZero) ||
                  (fmode && cur == lphe_pkg::NibOnes))) begin
        lead = lead + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    if (fmode && lead == 4'd8) begin
      lead = 4'd7;
    end
    head = fmode ? lead + 4'd8 : lead;
    vcnt = 4'd8 - lead;
    for (int j = 0; j < 16; j++) begin
      vi      = 5'(j) - 5'd1 - {4'b0, nibble_waiting};
      shifted = a_word >> {vi[2:0], 2'b00};
      if (nibble_waiting && j == 0) begin
        nib[j] = waiting_nibble;
      end else if (5'(j) == {4'b0, nibble_waiting}) begin
        nib[j] = head;
      end else if (5'(j) > {4'b0, nibble_waiting} && vi < {1'b0, vcnt}) begin
        nib[j] = shifted[3:0];
      end else begin
        nib[j] = lphe_pkg::NibZero;
      end
    end
    n    = {3'b0, nibble_waiting} + 4'd1 + vcnt;
    n_m1 = n - 4'd1;
    for (int i = 0; i < int'(lphe_pkg::MaxByte); i++) begin
      if (a_raw) begin
        job.bytes[i] = a_word[8*(i%4) +: 8];
      end else begin
        job.bytes[i] = {nib[2*i], nib[2*i+1]};
      end
    end
    if (a_raw) begin
      job.cnt = 3'(lphe_pkg::RawByte);
    end else if (a_eos) begin
      job.cnt = 3'((n + 4'd1) >> 1);
    end else begin
      job.cnt = 3'(n >> 1);
    end
  end

  assign job_valid = a_valid && (job.cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_waiting <= 1'b0;
      waiting_nibble <= '0;
    end else if (a_take) begin
      if (a_eos) begin
        nibble_waiting <= 1'b0;
        waiting_nibble <= '0;
      end else if (!a_raw) begin
        nibble_waiting <= n[0];
        waiting_nibble <= n[0] ? nib[n_m1] : lphe_pkg::NibZero;
      end
    end
  end

endmodule

### rtl/lphe_queue.sv
`timescale 1ns / 1ps

module lphe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lphe_pkg::job_t push_job,
  output logic           full,
  output logic           pop_valid,
  output lphe_pkg::job_t pop_job,
  input  logic           pop
);

  lphe_pkg::job_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_job   = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

### rtl/lphe_back.sv
`timescale 1ns / 1ps

module lphe_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  input  lphe_pkg::job_t             job,
  output logic                       job_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lphe_pkg::ByteW-1:0] out_byte,
  output logic                       last_of_run
);

  logic [lphe_pkg::CntW-1:0] idx;
  logic                      load;
  logic                      last;

  assign load    = job_valid && (!out_valid || !out_stall);
  assign last    = (idx == job.cnt - 3'd1);
  assign job_pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? '0 : idx + 3'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= job.bytes[idx];
      last_of_run <= last;
    end
  end

endmodule

### rtl/linear_predict_halfbyte_encoder.sv
`timescale 1ns / 1ps

// channel  direction  handshake             payload
// in       sink       in_valid / in_stall   sample_value[31:0], end_of_stream
// out      source     out_valid / out_stall out_byte[7:0], last_of_run
//
// One output byte per cycle while out_stall is low; at most one sample enters per
// cycle, and a sample yields 0 to 5 bytes, which leave one at a time through the
// single-byte output register. A first byte passes through the front's residual
// register, the job queue and the output register before it is valid. A two-entry
// job queue sits between the residual coder and the byte serializer. Synchronous
// reset clears the prediction and held-nibble state. in_stall rises only when
// the queue is full.

module linear_predict_halfbyte_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] sample_value,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run
);

  logic           f_valid;
  lphe_pkg::job_t f_job;
  logic           q_full;
  logic           q_valid;
  lphe_pkg::job_t q_job;
  logic           q_pop;

  lphe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample_value  (sample_value),
    .end_of_stream (end_of_stream),
    .job_valid     (f_valid),
    .job           (f_job),
    .job_full      (q_full)
  );

  lphe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_job  (f_job),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_job   (q_job),
    .pop       (q_pop)
  );

  lphe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (q_valid),
    .job         (q_job),
    .job_pop     (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule
